// ===== rtl/ffha_pkg.sv =====
// Shared constants, command codes and status types of the first-fit heap allocator.
package ffha_pkg;

    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_HEADER_BYTES = 9;
    localparam int DEF_MAX_BLOCKS   = 256;

    localparam int FIELD_W = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_SPACE   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RD_IDX,
        CMD_STEP,
        CMD_TAKE_WHOLE,
        CMD_SPLIT_INIT,
        CMD_RD_K,
        CMD_WR_K,
        CMD_INS_REM,
        CMD_INS_HEAD,
        CMD_APPEND,
        CMD_SET_ZERO,
        CMD_SET_SPACE,
        CMD_SET_UNKNOWN,
        CMD_SET_OK,
        CMD_RD_0,
        CMD_MG_LOAD,
        CMD_RD_R,
        CMD_MG_STEP,
        CMD_MG_FIN,
        CMD_PUSH
    } t_cmd;

    typedef struct packed {
        logic is_alloc;
        logic size_zero;
        logic addr_zero;
        logic count_zero;
        logic hit;
        logic can_split;
        logic scan_last;
        logic append_ok;
        logic shift_more;
        logic one_block;
        logic merge_last;
        logic out_busy;
    } t_dp_status;

endpackage

// ===== rtl/ffha_ifs.sv =====
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] request_size;
    logic [15:0] block_address;

    modport source (output valid, output kind, output request_size, output block_address,
                    input ready);
    modport sink (input valid, input kind, input request_size, input block_address,
                  output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_offset;
    logic [1:0]  status;

    modport source (output valid, output data_offset, output status, input ready);
    modport sink (input valid, input data_offset, input status, output ready);
endinterface

// ===== rtl/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ffha_dp.sv =====
// Datapath of the heap allocator: block table, scan, shift and merge registers, result stage.
module ffha_dp #(
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffha_pkg::t_cmd        i_cmd,
    output ffha_pkg::t_dp_status  o_stat,
    input  logic                  i_kind,
    input  logic [15:0]           i_request_size,
    input  logic [15:0]           i_block_address,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [15:0]           o_data_offset,
    output logic [1:0]            o_status
);

    localparam int AW    = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int OFS_W = (($clog2(HEAP_BYTES) > ffha_pkg::FIELD_W) ?
                            $clog2(HEAP_BYTES) : ffha_pkg::FIELD_W) + 2;
    localparam int EW    = OFS_W + 1;

    localparam logic [OFS_W-1:0] HDR  = OFS_W'(HEADER_BYTES);
    localparam logic [OFS_W-1:0] HEAP = OFS_W'(HEAP_BYTES);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    logic             r_kind, n_kind;
    logic [15:0]      r_size, n_size;
    logic [15:0]      r_addr, n_addr;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [OFS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [OFS_W-1:0] r_end, n_end;
    logic [OFS_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_r, n_r;
    logic [CNT_W-1:0] r_w, n_w;
    logic [OFS_W-1:0] r_acc_len, n_acc_len;
    logic             r_acc_free, n_acc_free;
    logic [15:0]      r_res_off, n_res_off;
    logic [1:0]       r_res_st, n_res_st;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_off, n_out_off;
    logic [1:0]       r_out_st, n_out_st;

    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [EW-1:0]    wdata;
    logic [CNT_W-1:0] raddr;
    logic [EW-1:0]    rdata;
    logic [OFS_W-1:0] d_len;
    logic             d_free;
    logic [OFS_W-1:0] size_ext;
    logic             e_free;

    ffha_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    assign d_len    = rdata[OFS_W-1:0];
    assign d_free   = rdata[OFS_W];
    assign size_ext = OFS_W'(r_size);
    assign e_free   = d_free | (r_r == r_idx);

    always_comb begin
        o_stat.is_alloc   = !r_kind;
        o_stat.size_zero  = (r_size == 16'd0);
        o_stat.addr_zero  = (r_addr == 16'd0);
        o_stat.count_zero = (r_count == '0);
        o_stat.hit        = r_kind ? (r_pos == OFS_W'(r_addr))
                                   : (d_free && (d_len >= size_ext));
        o_stat.can_split  = ((size_ext + HDR) < d_len) && (r_count < MAXC);
        o_stat.scan_last  = ((r_idx + ONE) == r_count);
        o_stat.append_ok  = (r_count < MAXC) && ((HDR + r_end + size_ext) < HEAP);
        o_stat.shift_more = (r_k > (r_idx + ONE));
        o_stat.one_block  = (r_count == ONE);
        o_stat.merge_last = ((r_r + ONE) == r_count);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    always_comb begin
        n_kind      = r_kind;
        n_size      = r_size;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_count     = r_count;
        n_end       = r_end;
        n_rem       = r_rem;
        n_k         = r_k;
        n_r         = r_r;
        n_w         = r_w;
        n_acc_len   = r_acc_len;
        n_acc_free  = r_acc_free;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        n_out_off   = r_out_off;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid && !i_out_ready;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = rdata;
        raddr       = r_idx;
        unique case (i_cmd)
            ffha_pkg::CMD_LOAD: begin
                n_kind = i_kind;
                n_size = i_request_size;
                n_addr = i_block_address;
                n_idx  = '0;
                n_pos  = HDR;
            end
            ffha_pkg::CMD_RD_IDX: begin
                raddr = r_idx;
            end
            ffha_pkg::CMD_STEP: begin
                n_pos = r_pos + HDR + d_len;
                n_idx = r_idx + ONE;
            end
            ffha_pkg::CMD_TAKE_WHOLE: begin
                we        = 1'b1;
                waddr     = r_idx;
                wdata     = {1'b0, d_len};
                n_res_off = r_pos[15:0];
                n_res_st  = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_SPLIT_INIT: begin
                n_rem = d_len - (size_ext + HDR);
                n_k   = r_count;
            end
            ffha_pkg::CMD_RD_K: begin
                raddr = r_k - ONE;
            end
            ffha_pkg::CMD_WR_K: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = rdata;
                n_k   = r_k - ONE;
            end
            ffha_pkg::CMD_INS_REM: begin
                we    = 1'b1;
                waddr = r_idx + ONE;
                wdata = {1'b1, r_rem};
            end
            ffha_pkg::CMD_INS_HEAD: begin
                we        = 1'b1;
                waddr     = r_idx;
                wdata     = {1'b0, size_ext};
                n_count   = r_count + ONE;
                n_res_off = r_pos[15:0];
                n_res_st  = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_APPEND: begin
                we        = 1'b1;
                waddr     = r_count;
                wdata     = {1'b0, size_ext};
                n_count   = r_count + ONE;
                n_end     = r_end + HDR + size_ext;
                n_res_off = 16'(r_end + HDR);
                n_res_st  = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_SET_ZERO: begin
                n_res_off = 16'd0;
                n_res_st  = ffha_pkg::ST_ZERO;
            end
            ffha_pkg::CMD_SET_SPACE: begin
                n_res_off = 16'd0;
                n_res_st  = ffha_pkg::ST_SPACE;
            end
            ffha_pkg::CMD_SET_UNKNOWN: begin
                n_res_off = 16'd0;
                n_res_st  = ffha_pkg::ST_UNKNOWN;
            end
            ffha_pkg::CMD_SET_OK: begin
                n_res_off = 16'd0;
                n_res_st  = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_RD_0: begin
                raddr = '0;
            end
            ffha_pkg::CMD_MG_LOAD: begin
                n_acc_len  = d_len;
                n_acc_free = d_free | (r_idx == '0);
                n_r        = ONE;
                n_w        = '0;
            end
            ffha_pkg::CMD_RD_R: begin
                raddr = r_r;
            end
            ffha_pkg::CMD_MG_STEP: begin
                // Adjacent free blocks fold into the accumulator; otherwise it is written back.
                if (r_acc_free && e_free) begin
                    n_acc_len = r_acc_len + HDR + d_len;
                end else begin
                    we         = 1'b1;
                    waddr      = r_w;
                    wdata      = {r_acc_free, r_acc_len};
                    n_w        = r_w + ONE;
                    n_acc_len  = d_len;
                    n_acc_free = e_free;
                end
                n_r = r_r + ONE;
            end
            ffha_pkg::CMD_MG_FIN: begin
                we        = 1'b1;
                waddr     = r_w;
                wdata     = {r_acc_free, r_acc_len};
                n_count   = r_w + ONE;
                n_res_off = 16'd0;
                n_res_st  = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_PUSH: begin
                n_out_valid = 1'b1;
                n_out_off   = r_res_off;
                n_out_st    = r_res_st;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_rem      <= n_rem;
        r_k        <= n_k;
        r_r        <= n_r;
        r_w        <= n_w;
        r_acc_len  <= n_acc_len;
        r_acc_free <= n_acc_free;
        r_res_off  <= n_res_off;
        r_res_st   <= n_res_st;
        r_out_off  <= n_out_off;
        r_out_st   <= n_out_st;
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_offset = r_out_off;
    assign o_status      = r_out_st;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Sequencer of the heap allocator: walks search, split shift, append and merge steps.
module ffha_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ffha_pkg::t_dp_status i_stat,
    output ffha_pkg::t_cmd       o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DECIDE   = 16'h0002,
        S_SCAN_RD  = 16'h0004,
        S_SCAN_CHK = 16'h0008,
        S_TAIL     = 16'h0010,
        S_SH_TEST  = 16'h0020,
        S_SH_RD    = 16'h0040,
        S_SH_WR    = 16'h0080,
        S_INS_REM  = 16'h0100,
        S_INS_HEAD = 16'h0200,
        S_MG_RD0   = 16'h0400,
        S_MG_LD0   = 16'h0800,
        S_MG_RD    = 16'h1000,
        S_MG_CHK   = 16'h2000,
        S_MG_FIN   = 16'h4000,
        S_FINISH   = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = ffha_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = ffha_pkg::CMD_LOAD;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.is_alloc && i_stat.size_zero) begin
                    o_cmd   = ffha_pkg::CMD_SET_ZERO;
                    n_state = S_FINISH;
                end else if (!i_stat.is_alloc && i_stat.addr_zero) begin
                    o_cmd   = ffha_pkg::CMD_SET_OK;
                    n_state = S_FINISH;
                end else if (i_stat.count_zero) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd   = ffha_pkg::CMD_RD_IDX;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_stat.hit && !i_stat.is_alloc) begin
                    n_state = S_MG_RD0;
                end else if (i_stat.hit && i_stat.can_split) begin
                    o_cmd   = ffha_pkg::CMD_SPLIT_INIT;
                    n_state = S_SH_TEST;
                end else if (i_stat.hit) begin
                    o_cmd   = ffha_pkg::CMD_TAKE_WHOLE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd   = ffha_pkg::CMD_STEP;
                    n_state = i_stat.scan_last ? S_TAIL : S_SCAN_RD;
                end
            end
            S_TAIL: begin
                if (!i_stat.is_alloc) begin
                    o_cmd = ffha_pkg::CMD_SET_UNKNOWN;
                end else if (i_stat.append_ok) begin
                    o_cmd = ffha_pkg::CMD_APPEND;
                end else begin
                    o_cmd = ffha_pkg::CMD_SET_SPACE;
                end
                n_state = S_FINISH;
            end
            S_SH_TEST: begin
                n_state = i_stat.shift_more ? S_SH_RD : S_INS_REM;
            end
            S_SH_RD: begin
                o_cmd   = ffha_pkg::CMD_RD_K;
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                o_cmd   = ffha_pkg::CMD_WR_K;
                n_state = S_SH_TEST;
            end
            S_INS_REM: begin
                o_cmd   = ffha_pkg::CMD_INS_REM;
                n_state = S_INS_HEAD;
            end
            S_INS_HEAD: begin
                o_cmd   = ffha_pkg::CMD_INS_HEAD;
                n_state = S_FINISH;
            end
            S_MG_RD0: begin
                o_cmd   = ffha_pkg::CMD_RD_0;
                n_state = S_MG_LD0;
            end
            S_MG_LD0: begin
                o_cmd   = ffha_pkg::CMD_MG_LOAD;
                n_state = i_stat.one_block ? S_MG_FIN : S_MG_RD;
            end
            S_MG_RD: begin
                o_cmd   = ffha_pkg::CMD_RD_R;
                n_state = S_MG_CHK;
            end
            S_MG_CHK: begin
                o_cmd   = ffha_pkg::CMD_MG_STEP;
                n_state = i_stat.merge_last ? S_MG_FIN : S_MG_RD;
            end
            S_MG_FIN: begin
                o_cmd   = ffha_pkg::CMD_MG_FIN;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = ffha_pkg::CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with split and coalesce.
// Usage: requests arrive as beats on i_req (kind 0 allocates request_size bytes,
// kind 1 frees the block whose data area starts at block_address). Every request
// yields exactly one response beat on o_rsp carrying data_offset and status.
// The block table lives in a single RAM with one write and one registered read
// port; each table entry visited takes a read step and then a step that uses its data.
// A zero size or a null free is answered straight from the decode step; otherwise
// the search visits the blocks in order. A whole-block take then finishes at once,
// while an append, a failed allocate or an unknown free passes through the tail
// step. A split shifts the later entries up one at a time and then writes the
// remainder and the head; a free that finds its block runs a merge pass over every block.
// One request is worked at a time; i_req.ready is high only while the sequencer
// is idle, so the next request is taken in the cycle its predecessor's result
// appears. A finished result sits in an output register, so the next request is
// taken while that result still waits on a stalled receiver; a second result then
// waits inside the block until the register frees up.
// Reset empties the heap (no blocks, end offset zero); table contents need no
// clearing since only entries below the block count are read.
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_rsp_if.source  o_rsp
);

    ffha_pkg::t_cmd       cmd;
    ffha_pkg::t_dp_status stat;

    // The sequencer only decides and holds its state; all other storage and arithmetic sit in the datapath.
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ffha_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_req.kind),
        .i_request_size  (i_req.request_size),
        .i_block_address (i_req.block_address),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_data_offset   (o_rsp.data_offset),
        .o_status        (o_rsp.status)
    );

endmodule
